FILE: rtl/b58sha_pkg.sv
// shared constants, types and helpers for the base58 nonce hasher
`timescale 1ns / 1ps
package b58sha_pkg;

    localparam int SuffixMaxBytes = 16;
    localparam int B58Digits = 11;
    localparam int DivStages = 11;
    localparam int DivParts = 8;
    localparam int DivPartBits = 64 / DivParts;
    localparam int EncStages = DivStages * DivParts;
    localparam int ShaRounds = 64;
    localparam logic [6:0] B58Radix = 7'd58;

    localparam logic [1:0] REG_SUFFIX_FIRST  = 2'd0;
    localparam logic [1:0] REG_SUFFIX_SECOND = 2'd1;
    localparam logic [1:0] REG_SUFFIX_LENGTH = 2'd2;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];
    typedef t_word t_sched [16];

    localparam t_word RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam t_word HInit [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    function automatic logic [7:0] b58_char(input logic [5:0] d);
        logic [7:0] c;
        begin
            if (d < 6'd9) c = 8'd49 + {2'b0, d};
            else if (d < 6'd17) c = 8'd56 + {2'b0, d};
            else if (d < 6'd22) c = 8'd57 + {2'b0, d};
            else if (d < 6'd33) c = 8'd58 + {2'b0, d};
            else if (d < 6'd44) c = 8'd64 + {2'b0, d};
            else c = 8'd65 + {2'b0, d};
            return c;
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: rtl/base58_nonce_sha256_search.sv
// top level: base58 encode a nonce, append suffix, sha-256 it
// pipeline: digit stages, a pack register, 64 round stages and an output register, in that order
// throughput: one nonce per cycle; the whole pipeline advances while the output is free
// stalls freeze every stage; the skid is the output register itself
// reset clears valid bits and suffix registers to zero
`timescale 1ns / 1ps
module base58_nonce_sha256_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_nonce,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word_a,
    output logic [63:0] o_digest_word_b,
    output logic [63:0] o_digest_word_c,
    output logic [63:0] o_digest_word_d,
    output logic [3:0]  o_encoded_length,
    output logic        o_hit
);
    localparam int R = b58sha_pkg::ShaRounds;
    logic [63:0] r_sfa, r_sfb;
    logic [4:0]  r_sfl;
    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfa <= '0; r_sfb <= '0; r_sfl <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                b58sha_pkg::REG_SUFFIX_FIRST:  r_sfa <= i_cfg_data;
                b58sha_pkg::REG_SUFFIX_SECOND: r_sfb <= i_cfg_data;
                b58sha_pkg::REG_SUFFIX_LENGTH: r_sfl <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic e_vld;
    logic [511:0] e_blk;
    logic [3:0] e_len;
    b58sha_enc u_enc (.i_clk, .i_rst_n, .i_en(en), .i_valid(i_valid), .i_nonce,
        .i_suf_a(r_sfa), .i_suf_b(r_sfb), .i_suf_len(r_sfl),
        .o_valid(e_vld), .o_block(e_blk), .o_len(e_len));

    b58sha_pkg::t_state st [R+1];
    b58sha_pkg::t_sched ws [R+1];
    logic r_v [R];
    logic [3:0] r_l [R];
    always_comb begin
        for (int k = 0; k < 8; k++) st[0][k] = b58sha_pkg::HInit[k];
        for (int k = 0; k < 16; k++) ws[0][k] = e_blk[511-32*k -: 32];
    end
    for (genvar g = 0; g < R; g++) begin : g_rnd
        b58sha_round u_rnd (.i_clk, .i_en(en), .i_idx(6'(g)), .i_st(st[g]), .i_w(ws[g]),
            .o_st(st[g+1]), .o_w(ws[g+1]));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < R; k++) r_v[k] <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v[0] <= e_vld;
            for (int k = 1; k < R; k++) r_v[k] <= r_v[k-1];
            o_valid <= r_v[R-1];
        end
    end
    b58sha_pkg::t_word h [8];
    always_comb
        for (int k = 0; k < 8; k++) h[k] = st[R][k] + b58sha_pkg::HInit[k];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l[0] <= e_len;
            for (int k = 1; k < R; k++) r_l[k] <= r_l[k-1];
            o_digest_word_a <= {h[0], h[1]};
            o_digest_word_b <= {h[2], h[3]};
            o_digest_word_c <= {h[4], h[5]};
            o_digest_word_d <= {h[6], h[7]};
            o_encoded_length <= r_l[R-1];
            o_hit <= (h[7][7:0] == 8'hff);
        end
    end
endmodule

FILE: rtl/b58sha_enc.sv
// base58 digit pipeline and message block assembly
`timescale 1ns / 1ps
module b58sha_enc (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_nonce,
    input  logic [63:0]   i_suf_a,
    input  logic [63:0]   i_suf_b,
    input  logic [4:0]    i_suf_len,
    output logic          o_valid,
    output logic [511:0]  o_block,
    output logic [3:0]    o_len
);
    localparam int NS = b58sha_pkg::EncStages;
    localparam int ND = b58sha_pkg::B58Digits;

    logic [63:0]  r_num [NS+1];
    logic [5:0]   r_rem [NS+1];
    logic [5:0]   r_dig [NS+1][ND];
    logic [3:0]   r_cnt [NS+1];
    logic         r_vld [NS+1];
    logic [511:0] r_block;
    logic [3:0]   r_len;
    logic         r_ovld;
    logic [511:0] n_block;
    logic [3:0]   n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_vld[s] <= 1'b0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= NS; s++) r_vld[s] <= r_vld[s-1];
            r_ovld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_nonce;
            r_cnt[0] <= 4'd0;
            for (int k = 0; k < ND; k++) r_dig[0][k] <= 6'd0;
            r_block <= n_block;
            r_len   <= n_len;
        end
    end

    // each digit is a restoring divide by 58, 8 dividend bits per stage;
    // quotient bits replace the dividend bits in place
    for (genvar s = 1; s <= NS; s++) begin : g_div
        localparam int P = (s - 1) % b58sha_pkg::DivParts;
        localparam int D = (s - 1) / b58sha_pkg::DivParts;
        localparam int Top = 63 - b58sha_pkg::DivPartBits * P;
        logic [63:0] n_num;
        logic [5:0]  n_rem;
        always_comb begin
            logic [6:0] acc;
            n_num = r_num[s-1];
            n_rem = (P == 0) ? 6'd0 : r_rem[s-1];
            for (int b = 0; b < b58sha_pkg::DivPartBits; b++) begin
                acc = {n_rem, n_num[Top - b]};
                if (acc >= b58sha_pkg::B58Radix) begin
                    n_rem = 6'(acc - b58sha_pkg::B58Radix);
                    n_num[Top - b] = 1'b1;
                end else begin
                    n_rem = acc[5:0];
                    n_num[Top - b] = 1'b0;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
                // a digit exists while the dividend entering it is nonzero
                if (P == 0) r_cnt[s] <= r_cnt[s-1] + {3'd0, (r_num[s-1] != 64'd0)};
                else r_cnt[s] <= r_cnt[s-1];
                for (int k = 0; k < ND; k++)
                    r_dig[s][k] <= (P == b58sha_pkg::DivParts - 1 && k == D) ? n_rem
                                                                           : r_dig[s-1][k];
            end
        end
    end

    always_comb begin
        logic [7:0] bytes [64];
        logic [4:0] slen;
        logic [6:0] len;
        logic [63:0] bits;
        n_len = r_cnt[NS];
        for (int j = 0; j < 64; j++) bytes[j] = 8'd0;
        for (int j = 0; j < ND; j++)
            if (4'(j) < n_len) bytes[j] = b58sha_pkg::b58_char(r_dig[NS][n_len - 4'd1 - 4'(j)]);
        slen = (32'(i_suf_len) > 32'(b58sha_pkg::SuffixMaxBytes))
             ? 5'(b58sha_pkg::SuffixMaxBytes) : i_suf_len;
        for (int j = 0; j < 16; j++)
            if (5'(j) < slen)
                bytes[6'(n_len) + 6'(j)] = (j < 8) ? i_suf_a[63-8*j -: 8]
                                                   : i_suf_b[63-8*(j-8) -: 8];
        len = 7'(n_len) + 7'(slen);
        bytes[len[5:0]] = 8'h80;
        bits = {54'd0, len, 3'd0};
        for (int j = 0; j < 8; j++) bytes[56+j] = bits[63-8*j -: 8];
        for (int j = 0; j < 64; j++) n_block[511-8*j -: 8] = bytes[j];
    end

    assign o_valid = r_ovld;
    assign o_block = r_block;
    assign o_len   = r_len;
endmodule

FILE: rtl/b58sha_round.sv
// one sha-256 round stage with its schedule window
`timescale 1ns / 1ps
module b58sha_round (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [5:0]        i_idx,
    input  b58sha_pkg::t_state i_st,
    input  b58sha_pkg::t_sched i_w,
    output b58sha_pkg::t_state o_st,
    output b58sha_pkg::t_sched o_w
);
    b58sha_pkg::t_word t1, t2, s0, s1, wn;
    always_comb begin
        t1 = i_st[7] + (b58sha_pkg::rotr(i_st[4],6) ^ b58sha_pkg::rotr(i_st[4],11)
             ^ b58sha_pkg::rotr(i_st[4],25)) + ((i_st[4] & i_st[5]) ^ (~i_st[4] & i_st[6]))
             + b58sha_pkg::RoundK[i_idx] + i_w[0];
        t2 = (b58sha_pkg::rotr(i_st[0],2) ^ b58sha_pkg::rotr(i_st[0],13)
             ^ b58sha_pkg::rotr(i_st[0],22)) + ((i_st[0] & i_st[1]) ^ (i_st[0] & i_st[2])
             ^ (i_st[1] & i_st[2]));
        s0 = b58sha_pkg::rotr(i_w[1],7) ^ b58sha_pkg::rotr(i_w[1],18) ^ (i_w[1] >> 3);
        s1 = b58sha_pkg::rotr(i_w[14],17) ^ b58sha_pkg::rotr(i_w[14],19) ^ (i_w[14] >> 10);
        wn = i_w[0] + s0 + i_w[9] + s1;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_st[0] <= t1 + t2;
            o_st[1] <= i_st[0];
            o_st[2] <= i_st[1];
            o_st[3] <= i_st[2];
            o_st[4] <= i_st[3] + t1;
            o_st[5] <= i_st[4];
            o_st[6] <= i_st[5];
            o_st[7] <= i_st[6];
            for (int k = 0; k < 15; k++) o_w[k] <= i_w[k+1];
            o_w[15] <= wn;
        end
    end
endmodule
